// File: rtl/core/polar_remap_address_generator_assert.svh
// Assertion macros for the polar remap address generator
`ifndef POLAR_REMAP_ADDRESS_GENERATOR_ASSERT_SVH
`define POLAR_REMAP_ADDRESS_GENERATOR_ASSERT_SVH
// implication checked on every edge outside reset
`define PRAG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// implication checked with the consequent in the cycle after the antecedent
`define PRAG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: rtl/core/prag_pkg.sv
// Shared constants, types and tables of the polar remap address generator
package prag_pkg;
   localparam int MAX_DIM = 4096;
   localparam int PHASE_BITS = 16;
   localparam int CORDIC_STEPS = 18;
   localparam int FRAC_BITS = 17;
   localparam int DIV_BITS = 12;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [1:0] REG_WIDTH = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_STEPS = 2'd2;

   typedef struct packed {
      logic [11:0] radius;
      logic [11:0] angle_row;
   } req_type;

   typedef struct packed {
      logic [11:0] source_x;
      logic [11:0] source_y;
      logic        inside_res;
   } rsp_type;

   function automatic logic signed [33:0] arc_at(input int i);
      logic signed [33:0] r;
      case (i)
         0: r = 34'sd536870912;  1: r = 34'sd316933406;  2: r = 34'sd167458908;
         3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
         6: r = 34'sd10679838;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
         9: r = 34'sd1335087;    10: r = 34'sd667544;    11: r = 34'sd333772;
         12: r = 34'sd166886;    13: r = 34'sd83443;     14: r = 34'sd41722;
         15: r = 34'sd20861;     16: r = 34'sd10430;     17: r = 34'sd5215;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction
endpackage

// File: rtl/core/prag_stream_if.sv
// Valid/ready stream interface
interface prag_stream_if #(parameter int WIDTH = 1);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/prag_phase_div.sv
// Pipelined restoring divider: phase = floor(row * 2^16 / steps), mod 2^16
module prag_phase_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  logic [11:0] in_row,
   input  logic [11:0] in_radius,
   input  logic [12:0] steps,
   output logic        out_valid,
   output logic [15:0] out_phase,
   output logic [11:0] out_radius
);
   // 28-bit dividend, quotient low 16 bits; two quotient bits per stage
   localparam int NB = 28;
   localparam int NS = NB / 2;
   logic [13:0]   rem_ff  [NS+1];
   logic [NB-1:0] num_ff  [NS+1];
   logic [15:0]   q_ff    [NS+1];
   logic [11:0]   rad_ff  [NS+1];
   logic [NS:0]   vld_ff;
   logic [12:0]   div;
   assign div = (steps == 13'd0) ? 13'd1 : steps;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[NS-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= '0;
         num_ff[0] <= {in_row, 16'd0};
         q_ff[0] <= '0;
         rad_ff[0] <= in_radius;
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_st
      logic [13:0] r1, r2;
      logic [14:0] t1, t2;
      logic        b1, b2;
      always_comb begin
         t1 = {rem_ff[s], num_ff[s][NB-1]} - {2'd0, div};
         b1 = !t1[14];
         r1 = b1 ? t1[13:0] : {rem_ff[s][12:0], num_ff[s][NB-1]};
         t2 = {r1, num_ff[s][NB-2]} - {2'd0, div};
         b2 = !t2[14];
         r2 = b2 ? t2[13:0] : {r1[12:0], num_ff[s][NB-2]};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s+1] <= r2;
            num_ff[s+1] <= {num_ff[s][NB-3:0], 2'b00};
            q_ff[s+1] <= {q_ff[s][13:0], b1, b2};
            rad_ff[s+1] <= rad_ff[s];
         end
      end
   end
   assign out_valid = vld_ff[NS];
   assign out_phase = q_ff[NS];
   assign out_radius = rad_ff[NS];
endmodule

// File: rtl/core/prag_cordic.sv
// Pipelined 18-step CORDIC, quadrant fold and Q1.17 rounding
module prag_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [15:0]        in_phase,
   input  logic [11:0]        in_radius,
   output logic               out_valid,
   output logic signed [18:0] out_cos,
   output logic signed [18:0] out_sin,
   output logic [11:0]        out_radius
);
   localparam int N = prag_pkg::CORDIC_STEPS;
   logic signed [33:0] x_ff [N+1];
   logic signed [33:0] y_ff [N+1];
   logic signed [33:0] z_ff [N+1];
   logic [1:0]         qd_ff [N+1];
   logic               zz_ff [N+1];
   logic [11:0]        rad_ff [N+1];
   logic [N+1:0]       vld_ff;
   logic signed [18:0] c_ff, s_ff;
   logic [11:0]        rado_ff;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[N:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0] <= prag_pkg::CORDIC_GAIN;
         y_ff[0] <= '0;
         z_ff[0] <= {4'd0, in_phase[13:0], 16'd0};
         qd_ff[0] <= in_phase[15:14];
         zz_ff[0] <= (in_phase[13:0] == 14'd0);
         rad_ff[0] <= in_radius;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_it
      logic signed [33:0] dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!z_ff[i][33]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - prag_pkg::arc_at(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + prag_pkg::arc_at(i);
            end
            qd_ff[i+1] <= qd_ff[i];
            zz_ff[i+1] <= zz_ff[i];
            rad_ff[i+1] <= rad_ff[i];
         end
      end
   end

   logic signed [33:0] c, s, rc, rs, tc, ts;
   always_comb begin
      c = zz_ff[N] ? 34'sd1073741824 : x_ff[N];
      s = zz_ff[N] ? 34'sd0 : y_ff[N];
      case (qd_ff[N])
         2'd0: begin rc = c; rs = s; end
         2'd1: begin rc = -s; rs = c; end
         2'd2: begin rc = -c; rs = -s; end
         default: begin rc = s; rs = -c; end
      endcase
      tc = (rc + 34'sd4096) >>> 13;
      ts = (rs + 34'sd4096) >>> 13;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff <= tc[18:0];
         s_ff <= ts[18:0];
         rado_ff <= rad_ff[N];
      end
   end
   assign out_valid = vld_ff[N+1];
   assign out_cos = c_ff;
   assign out_sin = s_ff;
   assign out_radius = rado_ff;
endmodule

// File: rtl/core/prag_coord.sv
// Multiply, truncate toward zero and bounds test
module prag_coord (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic signed [18:0] in_cos,
   input  logic signed [18:0] in_sin,
   input  logic [11:0]        in_radius,
   input  logic [12:0]        width,
   input  logic [12:0]        height,
   output logic               out_valid,
   output prag_pkg::rsp_type  out_rsp
);
   logic [1:0]         vld_ff;
   logic signed [31:0] px_ff, py_ff;
   prag_pkg::rsp_type  rsp_ff;
   logic [12:0]        w, h;
   logic signed [31:0] sx, sy, ax, ay;
   logic signed [14:0] x, y;
   logic               ins;

   always_comb begin
      w = (width > 13'd4096) ? 13'd4096 : width;
      h = (height > 13'd4096) ? 13'd4096 : height;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= $signed({1'b0, in_radius}) * in_cos;
         py_ff <= $signed({1'b0, in_radius}) * in_sin;
      end
   end

   always_comb begin
      // center in Q.17: (dim / 2) << 17
      sx = $signed({3'd0, w[12:1], 17'd0}) + px_ff;
      sy = $signed({3'd0, h[12:1], 17'd0}) - py_ff;
      // truncate toward zero: shift magnitude
      ax = sx[31] ? -sx : sx;
      ay = sy[31] ? -sy : sy;
      x = sx[31] ? -$signed({1'b0, ax[30:17]}) : $signed({1'b0, ax[30:17]});
      y = sy[31] ? -$signed({1'b0, ay[30:17]}) : $signed({1'b0, ay[30:17]});
      ins = !x[14] && (x < $signed({2'b0, w})) && !y[14] && (y < $signed({2'b0, h}));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.inside_res <= ins;
         rsp_ff.source_x <= ins ? x[11:0] : 12'd0;
         rsp_ff.source_y <= ins ? y[11:0] : 12'd0;
      end
   end
   assign out_valid = vld_ff[1];
   assign out_rsp = rsp_ff;
endmodule

// File: rtl/core/polar_remap_address_generator.sv
// Pipeline registers from accepted request beat to response beat
// (15 divider stages, 20 CORDIC stages, 2 multiply/bounds stages).
// Throughput: one beat per clock; the whole pipeline advances unless
// the output register holds an untaken beat.
// Reset: synchronous, clears all valid bits; registers return to 4096.
`include "polar_remap_address_generator_assert.svh"
module polar_remap_address_generator (
   input  logic        clock,
   input  logic        reset,
   prag_stream_if.sink   req,
   prag_stream_if.source rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   logic [12:0] width_ff, height_ff, steps_ff;
   logic        adv;
   logic        dv, cv, ov, out_ff;
   logic [15:0] ph;
   logic [11:0] r1, r2;
   logic signed [18:0] co, si;
   prag_pkg::rsp_type rs;
   prag_pkg::req_type rq;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 13'd4096; height_ff <= 13'd4096; steps_ff <= 13'd4096;
      end else if (csr_we) begin
         case (csr_index)
            prag_pkg::REG_WIDTH:  width_ff <= csr_wdata;
            prag_pkg::REG_HEIGHT: height_ff <= csr_wdata;
            prag_pkg::REG_STEPS:  steps_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stall only when the output holds a beat that is not taken
   assign adv = !ov || rsp.ready;
   assign req.ready = adv;
   assign rq = req.data;

   prag_phase_div u_div (.clock, .reset, .adv, .in_valid(req.valid && adv),
      .in_row(rq.angle_row), .in_radius(rq.radius), .steps(steps_ff),
      .out_valid(dv), .out_phase(ph), .out_radius(r1));
   prag_cordic u_cordic (.clock, .reset, .adv, .in_valid(dv), .in_phase(ph),
      .in_radius(r1), .out_valid(cv), .out_cos(co), .out_sin(si), .out_radius(r2));
   prag_coord u_coord (.clock, .reset, .adv, .in_valid(cv), .in_cos(co), .in_sin(si),
      .in_radius(r2), .width(width_ff), .height(height_ff), .out_valid(ov),
      .out_rsp(rs));

   assign out_ff = ov;
   assign rsp.valid = ov;
   assign rsp.data = rs;

   `PRAG_ASSERT_IMP(a_ready_when_empty, clock, reset, !out_ff, req.ready)
   `PRAG_ASSERT_NEXT(a_hold_on_stall, clock, reset, rsp.valid && !rsp.ready, $stable(rsp.data) && rsp.valid)
   `PRAG_ASSERT_IMP(a_zero_outside, clock, reset, rsp.valid && !rs.inside_res, rs.source_x == 12'd0 && rs.source_y == 12'd0)
endmodule

// File: test/polar_remap_address_generator_checker.sv
// Scoreboard for the polar remap address generator: tracks registers, predicts addresses
`timescale 1ns / 1ps
module polar_remap_address_generator_checker (
   input  logic        clock,
   input  logic        reset,
   prag_stream_if      req,
   prag_stream_if      rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata,
   output int          fail_count,
   output int          addr_pending,
   output int          addr_checked,
   output int          inside_seen
);
   localparam longint ARC_TURN [18] = '{
      536870912, 316933406, 167458908, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215};

   logic [12:0] img_width, img_height, turn_rows;
   prag_pkg::rsp_type addr_queue[$];

   // Q1.17 cos/sin of a 32-bit phase, CORDIC on the in-quadrant angle then quadrant fold
   function automatic void rotate_phase(input logic [31:0] ph, output longint cq,
                                        output longint sq);
      longint z, xv, yv, dx, dy, c, s, rc, rs;
      z = longint'(ph[29:0]);
      if (z == 0) begin
         c = longint'(1) << 30;
         s = 0;
      end else begin
         xv = 652032874;
         yv = 0;
         for (int i = 0; i < 18; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (z >= 0) begin
               xv -= dx; yv += dy; z -= ARC_TURN[i];
            end else begin
               xv += dx; yv -= dy; z += ARC_TURN[i];
            end
         end
         c = xv;
         s = yv;
      end
      case (ph[31:30])
         2'd0: begin rc = c; rs = s; end
         2'd1: begin rc = -s; rs = c; end
         2'd2: begin rc = -c; rs = -s; end
         default: begin rc = s; rs = -c; end
      endcase
      cq = (rc + 4096) >>> 13;
      sq = (rs + 4096) >>> 13;
   endfunction

   function automatic longint trunc_q17(input longint v);
      return (v >= 0) ? (v >>> 17) : -((-v) >>> 17);
   endfunction

   function automatic prag_pkg::rsp_type predict_address(input prag_pkg::req_type q);
      prag_pkg::rsp_type res;
      longint w, h, steps, phase, cq, sq, xs, ys, rr;
      w = (img_width > 4096) ? 4096 : img_width;
      h = (img_height > 4096) ? 4096 : img_height;
      steps = (turn_rows == 0) ? 1 : turn_rows;
      phase = ((longint'(q.angle_row) << 16) / steps) & 64'hFFFF;
      rotate_phase(32'(phase << 16), cq, sq);
      rr = longint'(q.radius);
      xs = trunc_q17((w / 2) * 131072 + rr * cq);
      ys = trunc_q17((h / 2) * 131072 - rr * sq);
      res = '0;
      if (xs >= 0 && xs < w && ys >= 0 && ys < h) begin
         res.source_x = xs[11:0];
         res.source_y = ys[11:0];
         res.inside_res = 1'b1;
      end
      return res;
   endfunction

   assign addr_pending = addr_queue.size();

   always @(posedge clock) begin
      prag_pkg::rsp_type got, want;
      if (reset) begin
         img_width <= 13'd4096;
         img_height <= 13'd4096;
         turn_rows <= 13'd4096;
         addr_queue.delete();
         fail_count <= 0;
         addr_checked <= 0;
         inside_seen <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               prag_pkg::REG_WIDTH: img_width <= csr_wdata;
               prag_pkg::REG_HEIGHT: img_height <= csr_wdata;
               prag_pkg::REG_STEPS: turn_rows <= csr_wdata;
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            addr_queue.push_back(predict_address(req.data));
         if (rsp.valid && rsp.ready) begin
            got = rsp.data;
            addr_checked <= addr_checked + 1;
            if (got.inside_res) inside_seen <= inside_seen + 1;
            if (addr_queue.size() == 0) begin
               $error("unexpected result beat %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = addr_queue.pop_front();
               if (got.source_x !== want.source_x)
                  $error("source_x expected %0d got %0d", want.source_x, got.source_x);
               if (got.source_y !== want.source_y)
                  $error("source_y expected %0d got %0d", want.source_y, got.source_y);
               if (got.inside_res !== want.inside_res)
                  $error("inside_res expected %0d got %0d", want.inside_res,
                         got.inside_res);
               if (got !== want) fail_count <= fail_count + 1;
            end
         end
      end
   end
endmodule

// File: test/polar_remap_address_generator_test.sv
// Top of the polar remap address generator testbench: stimulus, register phases, verdict
`timescale 1ns / 1ps
module polar_remap_address_generator_test;
   localparam int STALL_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = prag_pkg::REG_WIDTH;
   logic [12:0] csr_wdata = '0;
   int fail_count, addr_pending, addr_checked, inside_seen;
   int idle_cycles = 0;
   int stall_left = 0;
   int sent = 0;
   logic [12:0] cur_w = 13'd4096, cur_h = 13'd4096, cur_steps = 13'd4096;

   prag_stream_if #(.WIDTH(24)) req ();
   prag_stream_if #(.WIDTH(25)) rsp ();

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
   end

   always #5 clock = ~clock;

   polar_remap_address_generator uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   polar_remap_address_generator_checker scoreboard (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .addr_pending(addr_pending),
      .addr_checked(addr_checked), .inside_seen(inside_seen));

   // result-side backpressure: bursts of stall, mostly short
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50)
                                                    : $urandom_range(0, 3);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", addr_pending);
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_polar(input logic [11:0] radius, input logic [11:0] row);
      prag_pkg::req_type beat;
      logic fire;
      beat.radius = radius;
      beat.angle_row = row;
      req.valid <= 1'b1;
      req.data <= beat;
      do begin
         @(negedge clock);
         fire = req.valid && req.ready;
         @(posedge clock);
      end while (!fire);
      sent++;
      if ($urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat (($urandom_range(0, 12) == 0) ? $urandom_range(8, 40)
                                              : $urandom_range(1, 3))
            @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // let the last accepted beat reach the scoreboard before polling
   task automatic drain();
      req.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (addr_pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_image(input logic [12:0] w, input logic [12:0] h,
                            input logic [12:0] steps);
      drain();
      write_reg(prag_pkg::REG_WIDTH, w);
      write_reg(prag_pkg::REG_HEIGHT, h);
      write_reg(prag_pkg::REG_STEPS, steps);
      cur_w = w;
      cur_h = h;
      cur_steps = steps;
   endtask

   task automatic random_sweep(input int count);
      int reach, span;
      logic [11:0] r, row;
      reach = ((cur_w > cur_h) ? cur_w : cur_h) / 2 + 4;
      if (reach > 4095) reach = 4095;
      span = (cur_steps == 0) ? 0 : cur_steps - 1;
      if (span > 4095) span = 4095;
      repeat (count) begin
         r = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, reach));
         row = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, span));
         send_polar(r, row);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset geometry: axes, quadrant edges, field extremes
      send_polar(12'd0, 12'd0);
      send_polar(12'd4095, 12'd0);
      send_polar(12'd2047, 12'd0);
      send_polar(12'd2048, 12'd0);
      send_polar(12'd2047, 12'd1024);
      send_polar(12'd2048, 12'd1024);
      send_polar(12'd2048, 12'd2048);
      send_polar(12'd2047, 12'd3072);
      send_polar(12'd2048, 12'd3072);
      send_polar(12'd1000, 12'd512);
      send_polar(12'd4095, 12'd4095);
      send_polar(12'd1, 12'd1);
      random_sweep(30);

      // one row per turn, tiny image, and the ignored index
      set_image(13'd1, 13'd1, 13'd1);
      write_reg(2'd3, 13'h1FFF);
      send_polar(12'd0, 12'd0);
      send_polar(12'd1, 12'd4095);
      send_polar(12'd0, 12'd7);
      random_sweep(40);

      // oversize saturates, zero steps collapses the phase
      set_image(13'h1FFF, 13'd8191, 13'd0);
      send_polar(12'd2047, 12'd3);
      send_polar(12'd2048, 12'd4095);
      random_sweep(60);

      // empty image: nothing is inside
      set_image(13'd0, 13'd0, 13'd360);
      send_polar(12'd0, 12'd0);
      send_polar(12'd5, 12'd90);
      random_sweep(30);

      // rows wrap past angle_steps
      set_image(13'd640, 13'd480, 13'd360);
      send_polar(12'd100, 12'd360);
      send_polar(12'd100, 12'd720);
      send_polar(12'd239, 12'd270);
      send_polar(12'd240, 12'd270);
      random_sweep(150);

      set_image(13'd7, 13'd5, 13'd3);
      random_sweep(80);

      set_image(13'd4096, 13'd4096, 13'd4096);
      random_sweep(150);

      repeat (4) begin
         set_image(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                   13'($urandom_range(1, 4096)));
         random_sweep(110);
      end

      drain();
      $display("sent %0d polar pixels across 11 geometries; %0d results checked, %0d inside",
               sent, addr_checked, inside_seen);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/prag_pkg.sv
rtl/core/prag_stream_if.sv
rtl/core/prag_phase_div.sv
rtl/core/prag_cordic.sv
rtl/core/prag_coord.sv
rtl/core/polar_remap_address_generator.sv
test/polar_remap_address_generator_checker.sv
test/polar_remap_address_generator_test.sv
